>>> src/sbst_pkg.sv
// Shared constants and controller/datapath interface types for the second-best spanning tree unit.
`default_nettype none
package sbst_pkg;
  localparam int MaxVertices = 1024;
  localparam int MaxEdges    = 4096;
  localparam int VBits       = 10;   // vertex index
  localparam int VcBits      = 11;   // vertex count
  localparam int EBits       = 12;   // edge store index
  localparam int EcBits      = 13;   // edge count
  localparam int WBits       = 20;   // weight
  localparam int RBits       = 4;    // rank
  localparam int CBits       = 30;   // cost
  localparam int EdgeBits    = 2 * VBits + WBits;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;        // store accepted edge word
    logic sort_init;   // i <= 1
    logic rd_i;        // read edge at i
    logic rd_jm1;      // read edge at j-1
    logic rd_k;        // read edge at k
    logic sort_key;    // latch key, j <= i
    logic sort_shift;  // mem[j] <= read word, j--
    logic sort_place;  // mem[j] <= key, i++
    logic pass_start;  // clear pass counters
    logic init_step;   // reset one union-find entry
    logic k_clear;
    logic k_inc;
    logic edge_latch;  // hold to end and weight of edge k
    logic find_a;      // cur <= from end
    logic find_adv;    // cur <= parent
    logic root_a;      // ra <= cur, cur <= to end
    logic root_b;      // rb <= cur
    logic union_do;
    logic pass_end;
    logic emit;        // load result, clear edge store
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic i_done;
    logic j_zero;
    logic shift_need;
    logic init_done;
    logic k_done;
    logic tree_full;
    logic is_skip;
    logic out_range;
    logic is_root;
    logic same_root;
    logic skipping;
    logic last_skip;
    logic empty;
    logic out_busy;
  } status_t;
endpackage
`default_nettype wire

>>> src/sbst_ctrl.sv
// Controller state machine: load, insertion sort, Kruskal passes, result hand-off.
`default_nettype none
module sbst_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            in_last,
  output logic                 in_ready,
  input  sbst_pkg::status_t    st,
  output sbst_pkg::cmd_t       cmd
);
  localparam logic [4:0] IDLE = 5'd0, S_OUT = 5'd1, S_KEYW = 5'd2, S_CMP = 5'd3,
    S_CMPW = 5'd4, S_PLACE = 5'd5, P_START = 5'd6, P_INIT = 5'd7, P_EDGE = 5'd8,
    P_EDGEW = 5'd9, P_FINDA = 5'd10, P_FINDAW = 5'd11, P_FINDB = 5'd12,
    P_FINDBW = 5'd13, P_URD = 5'd14, P_UNION = 5'd15, P_END = 5'd16, DONE = 5'd17;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= IDLE;
    else     state <= state_next;
  end

  assign in_ready = (state == IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.sort_init = 1'b1;
            state_next = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (st.i_done) state_next = P_START;
        else begin
          cmd.rd_i = 1'b1;
          state_next = S_KEYW;
        end
      end
      S_KEYW: begin
        cmd.sort_key = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (st.j_zero) state_next = S_PLACE;
        else begin
          cmd.rd_jm1 = 1'b1;
          state_next = S_CMPW;
        end
      end
      S_CMPW: begin
        if (st.shift_need) begin
          cmd.sort_shift = 1'b1;
          state_next = S_CMP;
        end else state_next = S_PLACE;
      end
      S_PLACE: begin
        cmd.sort_place = 1'b1;
        state_next = S_OUT;
      end
      P_START: begin
        cmd.pass_start = 1'b1;
        state_next = P_INIT;
      end
      P_INIT: begin
        if (st.init_done) begin
          cmd.k_clear = 1'b1;
          state_next = P_EDGE;
        end else cmd.init_step = 1'b1;
      end
      P_EDGE: begin
        if (st.k_done || st.tree_full) state_next = P_END;
        else if (st.is_skip) cmd.k_inc = 1'b1;
        else begin
          cmd.rd_k = 1'b1;
          state_next = P_EDGEW;
        end
      end
      P_EDGEW: begin
        cmd.edge_latch = 1'b1;
        if (st.out_range) begin
          cmd.k_inc = 1'b1;
          state_next = P_EDGE;
        end else begin
          cmd.find_a = 1'b1;
          state_next = P_FINDA;
        end
      end
      P_FINDA: state_next = P_FINDAW;
      P_FINDAW: begin
        if (st.is_root) begin
          cmd.root_a = 1'b1;
          state_next = P_FINDB;
        end else begin
          cmd.find_adv = 1'b1;
          state_next = P_FINDA;
        end
      end
      P_FINDB: state_next = P_FINDBW;
      P_FINDBW: begin
        if (st.is_root) begin
          cmd.root_b = 1'b1;
          state_next = P_URD;
        end else begin
          cmd.find_adv = 1'b1;
          state_next = P_FINDB;
        end
      end
      P_URD: state_next = P_UNION;
      P_UNION: begin
        if (st.same_root) cmd.k_inc = 1'b1;
        else cmd.union_do = 1'b1;
        state_next = P_EDGE;
      end
      P_END: begin
        cmd.pass_end = 1'b1;
        if (!st.skipping) state_next = st.empty ? DONE : P_START;
        else state_next = st.last_skip ? DONE : P_START;
      end
      DONE: begin
        if (!st.out_busy) begin
          cmd.emit = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> src/sbst_dp.sv
// Datapath: edge store, union-find stores, counters, cost tracking and result register.
`default_nettype none
module sbst_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  sbst_pkg::cmd_t                       cmd,
  output sbst_pkg::status_t                    st,
  input  wire logic [sbst_pkg::EdgeBits-1:0]   in_word,
  input  wire logic                            cfg_wr_en,
  input  wire logic [sbst_pkg::VcBits-1:0]     cfg_wr_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [63:0]                          out_word
);
  localparam int VB = sbst_pkg::VBits;
  localparam int EB = sbst_pkg::EBits;
  localparam int EC = sbst_pkg::EcBits;
  localparam int VC = sbst_pkg::VcBits;
  localparam int WB = sbst_pkg::WBits;
  localparam int RB = sbst_pkg::RBits;
  localparam int CB = sbst_pkg::CBits;
  localparam int DW = sbst_pkg::EdgeBits;

  logic [DW-1:0] emem [sbst_pkg::MaxEdges];
  logic [VB-1:0] pmem [sbst_pkg::MaxVertices];
  logic [RB-1:0] rmem [sbst_pkg::MaxVertices];

  logic [VC-1:0] vcount, n, v, taken;
  logic [EC-1:0] ecnt, i, j, k, skip;
  logic [DW-1:0] key, erd;
  logic [VB-1:0] eb, cur, pd, ra, rb;
  logic [WB-1:0] ew;
  logic [RB-1:0] rka, rkb;
  logic [CB-1:0] cost, best, runner, min_q, sec_q;
  logic          skipping, rvalid, found_q;
  logic [EB-1:0] eaddr;
  logic [VC-1:0] n_eff;

  assign n_eff = (vcount > VC'(sbst_pkg::MaxVertices)) ? VC'(sbst_pkg::MaxVertices) : vcount;

  // edge store read address select
  always_comb begin
    if (cmd.rd_i)        eaddr = i[EB-1:0];
    else if (cmd.rd_jm1) eaddr = j[EB-1:0] - EB'(1);
    else if (cmd.rd_k)   eaddr = k[EB-1:0];
    else                 eaddr = i[EB-1:0];  // read data unused
  end

  // edge store
  always_ff @(posedge clk) begin
    erd <= emem[eaddr];
    if (cmd.load && (ecnt < EC'(sbst_pkg::MaxEdges))) emem[ecnt[EB-1:0]] <= in_word;
    else if (cmd.sort_shift) emem[j[EB-1:0]] <= erd;
    else if (cmd.sort_place) emem[j[EB-1:0]] <= key;
  end

  // union-find stores
  logic          a_wins;
  logic [VB-1:0] win, lose;
  assign a_wins = !(rka < rkb);
  assign win    = a_wins ? ra : rb;
  assign lose   = a_wins ? rb : ra;

  always_ff @(posedge clk) begin
    pd  <= pmem[cur];
    rka <= rmem[ra];
    rkb <= rmem[rb];
    if (cmd.init_step) begin
      pmem[v[VB-1:0]] <= v[VB-1:0];
      rmem[v[VB-1:0]] <= '0;
    end else if (cmd.union_do) begin
      pmem[lose] <= win;
      if (rka == rkb) rmem[win] <= (a_wins ? rka : rkb) + RB'(1);
    end
  end

  // configuration, counters and cost tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount    <= VC'(1);
      ecnt      <= '0;
      skipping  <= 1'b0;
      out_valid <= 1'b0;
      best      <= '0;
      runner    <= '0;
      rvalid    <= 1'b0;
    end else begin
      if (cfg_wr_en) vcount <= cfg_wr_data;
      if (cmd.load && (ecnt < EC'(sbst_pkg::MaxEdges))) ecnt <= ecnt + EC'(1);
      if (cmd.pass_end) begin
        if (!skipping) begin
          best     <= cost;
          skipping <= 1'b1;
          runner   <= '0;
          rvalid   <= 1'b0;
        end else if (cost > best && (!rvalid || cost < runner)) begin
          runner <= cost;
          rvalid <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        ecnt      <= '0;
        skipping  <= 1'b0;
      end else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.sort_init) i <= EC'(1);
    if (cmd.sort_place) i <= i + EC'(1);
    if (cmd.sort_key) begin
      key <= erd;
      j   <= i;
    end
    if (cmd.sort_shift) j <= j - EC'(1);
    if (cmd.pass_start) begin
      n     <= n_eff;
      taken <= '0;
      cost  <= '0;
      v     <= '0;
    end
    if (cmd.init_step) v <= v + VC'(1);
    if (cmd.k_clear) k <= '0;
    if (cmd.k_inc || cmd.union_do) k <= k + EC'(1);
    if (cmd.edge_latch) begin
      eb <= erd[2*VB-1:VB];
      ew <= erd[DW-1:2*VB];
    end
    if (cmd.find_a) cur <= erd[VB-1:0];
    if (cmd.find_adv) cur <= pd;
    if (cmd.root_a) begin
      ra  <= cur;
      cur <= eb;
    end
    if (cmd.root_b) rb <= cur;
    if (cmd.union_do) begin
      cost  <= cost + CB'(ew);
      taken <= taken + VC'(1);
    end
    if (cmd.pass_end) skip <= skipping ? skip + EC'(1) : '0;
    if (cmd.emit) begin
      min_q   <= best;
      sec_q   <= runner;
      found_q <= rvalid;
    end
  end

  // status
  always_comb begin
    st.i_done     = (i >= ecnt);
    st.j_zero     = (j == '0);
    st.shift_need = (erd[DW-1:2*VB] > key[DW-1:2*VB]);
    st.init_done  = (v >= n);
    st.k_done     = (k >= ecnt);
    st.tree_full  = (n != '0) && (taken + VC'(1) == n);
    st.is_skip    = skipping && (k == skip);
    st.out_range  = ({1'b0, erd[VB-1:0]} >= n) || ({1'b0, erd[2*VB-1:VB]} >= n);
    st.is_root    = (pd == cur);
    st.same_root  = (ra == rb);
    st.skipping   = skipping;
    st.last_skip  = (skip + EC'(1) == ecnt);
    st.empty      = (ecnt == '0);
    st.out_busy   = out_valid;
  end

  assign out_word = {3'b000, found_q, sec_q, min_q};
endmodule
`default_nettype wire

>>> src/second_best_spanning_tree_cost_top.sv
// Top level of the second-best spanning tree cost unit.
// Usage:
//   Edges arrive on the s_axis channel, one word each: from, to and weight in
//   tdata, tlast marking the final edge of a graph. vertex_count is written
//   through cfg_wr_en/cfg_wr_data while the unit is idle.
//   Each edge is taken while the unit is idle. After the last edge the unit
//   sorts the edge store (insertion sort, at most one store access per
//   cycle) and then runs E+1 Kruskal passes. Each pass clears the
//   union-find, then for each edge reads it, follows parents in the find of
//   each end and unions the roots if they differ; a left-out edge is skipped.
//   One result word per graph appears on m_axis and is held until taken.
//   New edges are accepted while a result waits; a further last edge waits
//   at the end of its computation until the output register is free.
//   Reset empties the edge store, sets vertex_count to 1 and drops any
//   pending result.
`default_nettype none
module second_best_spanning_tree_cost_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // from_vertex, to_vertex, edge_weight
  input  wire logic        s_axis_tlast,   // last_edge
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // minimum cost, second_cost, second_found, zero pad
  input  wire logic        cfg_wr_en,
  input  wire logic [10:0] cfg_wr_data     // vertex_count
);
  sbst_pkg::cmd_t    cmd;
  sbst_pkg::status_t st;

  sbst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  sbst_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .in_word     (s_axis_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_word    (m_axis_tdata)
  );
endmodule
`default_nettype wire

>>> src/sbst_checker.sv
// Port-level checker for the second-best spanning tree unit, with its bind.
`default_nettype none
module sbst_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata
);
  // stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed under stall");

  // no second cost reported as zero
  a_nosec: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[60] |-> m_axis_tdata[59:30] == 30'd0)
    else $error("second cost nonzero without flag");

  // second cost lies strictly above the minimum
  a_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[60] |-> m_axis_tdata[59:30] > m_axis_tdata[29:0])
    else $error("second cost not above minimum");

  // a last edge starts computation, input closes
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input open right after last edge");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[63:61] == 3'd0)
    else $error("pad bits set");
endmodule

bind second_best_spanning_tree_cost_top sbst_checker u_sbst_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
